>>> rtl/bbps_pkg.sv
// Package for the ball bounce physics step unit.
// Holds the fixed-point constants, the register map, the microcode word and its program.
// It depends on nothing else.
package bbps_pkg;

   localparam int POS_W  = 22;
   localparam int DT_W   = 16;
   localparam int PIX_W  = 12;
   localparam int FAC_W  = 9;
   localparam int MULB_W = 18;
   localparam int PROD_W = POS_W + MULB_W;
   localparam int SUM_W  = 33;
   localparam int STEP_W = 4;

   localparam int GRAVITY     = 800;
   localparam int FIELD_WIDTH = 1280;

   localparam logic signed [POS_W-1:0] GRAVITY_Q    = POS_W'(GRAVITY);
   localparam logic signed [POS_W-1:0] BOUNCE_MIN_V = -POS_W'(50 * 256);
   localparam logic signed [POS_W-1:0] STOP_HI      = POS_W'(5 * 256);
   localparam logic signed [POS_W-1:0] STOP_LO      = -POS_W'(5 * 256);
   localparam logic [PIX_W-1:0]        NET_LEFT_X   = PIX_W'(10);
   localparam logic [PIX_W-1:0]        NET_RIGHT_X  = PIX_W'(FIELD_WIDTH - 10);
   localparam logic [PIX_W:0]          WALL_MARGIN  = (PIX_W + 1)'(16);

   localparam logic signed [POS_W-1:0] V_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] V_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef enum logic [2:0] {
      CSR_BOUNCE_FACTOR = 3'd0,
      CSR_FRICTION      = 3'd1,
      CSR_LEFT_WALL     = 3'd2,
      CSR_RIGHT_WALL    = 3'd3,
      CSR_TOP_WALL      = 3'd4,
      CSR_BOTTOM_WALL   = 3'd5,
      CSR_POST_UPPER    = 3'd6,
      CSR_POST_LOWER    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_KICK  = 2'd1,
      REQ_PLACE = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [FAC_W-1:0] bounce_factor;
      logic [FAC_W-1:0] friction;
      logic [PIX_W-1:0] left_wall;
      logic [PIX_W-1:0] right_wall;
      logic [PIX_W-1:0] top_wall;
      logic [PIX_W-1:0] bottom_wall;
      logic [PIX_W-1:0] post_upper;
      logic [PIX_W-1:0] post_lower;
   } cfg_type;

   typedef struct packed {
      logic [DT_W-1:0]         dt;
      logic signed [POS_W-1:0] kick_x;
      logic signed [POS_W-1:0] kick_y;
      logic signed [POS_W-1:0] kick_z;
      logic [POS_W-3:0]        place_x;
      logic [POS_W-3:0]        place_y;
   } item_type;

   typedef enum logic [1:0] {A_VX, A_VY, A_VZ, A_GRAV} mul_a_type;
   typedef enum logic [1:0] {B_DT, B_NBOUNCE, B_FRICTION} mul_b_type;
   typedef enum logic [2:0] {D_NONE, D_PX, D_PY, D_PZ, D_VX, D_VY, D_VZ} dst_type;
   typedef enum logic [2:0] {
      WB_ADD16, WB_SUB8, WB_ROLL, WB_BOUNCE_Z, WB_BOUNCE_X, WB_BOUNCE_Y
   } wb_mode_type;
   typedef enum logic [1:0] {M_NONE, M_KICK, M_PLACE, M_CLR_PZ} misc_type;

   typedef struct packed {
      logic              mul_en;
      mul_a_type         mul_a;
      mul_b_type         mul_b;
      dst_type           dst;
      wb_mode_type       mode;
      misc_type          misc;
      logic              jmp_air;
      logic [STEP_W-1:0] target;
      logic              last;
   } uword_type;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_RUN, SEQ_POST} seq_state_type;

   localparam logic [STEP_W-1:0] ENTRY_TICK  = STEP_W'(0);
   localparam logic [STEP_W-1:0] WALL_STEP   = STEP_W'(9);
   localparam logic [STEP_W-1:0] ENTRY_KICK  = STEP_W'(12);
   localparam logic [STEP_W-1:0] ENTRY_PLACE = STEP_W'(13);
   localparam logic [STEP_W-1:0] ENTRY_NONE  = STEP_W'(14);

   function automatic logic [STEP_W-1:0] entry_of(req_code_type code);
      logic [STEP_W-1:0] e;
      case (code)
         REQ_TICK:  e = ENTRY_TICK;
         REQ_KICK:  e = ENTRY_KICK;
         REQ_PLACE: e = ENTRY_PLACE;
         default:   e = ENTRY_NONE;
      endcase
      return e;
   endfunction

   function automatic uword_type mop(logic me, mul_a_type a, mul_b_type b, dst_type d,
                                     wb_mode_type m);
      uword_type w;
      w        = '0;
      w.mul_en = me;
      w.mul_a  = a;
      w.mul_b  = b;
      w.dst    = d;
      w.mode   = m;
      return w;
   endfunction

   // Tick program: integrate, ground contact, two wall axes; then kick and place.
   function automatic uword_type ucode(logic [STEP_W-1:0] step);
      uword_type w;
      w = '0;
      case (step)
         4'd0:  w = mop(1'b1, A_GRAV, B_DT, D_NONE, WB_ADD16);
         4'd1:  w = mop(1'b1, A_VX, B_DT, D_VZ, WB_SUB8);
         4'd2:  w = mop(1'b1, A_VY, B_DT, D_PX, WB_ADD16);
         4'd3:  w = mop(1'b1, A_VZ, B_DT, D_PY, WB_ADD16);
         4'd4:  w = mop(1'b0, A_VX, B_DT, D_PZ, WB_ADD16);
         4'd5: begin
            w         = mop(1'b1, A_VX, B_FRICTION, D_NONE, WB_ADD16);
            w.jmp_air = 1'b1;
            w.target  = WALL_STEP;
         end
         4'd6: begin
            w      = mop(1'b1, A_VY, B_FRICTION, D_VX, WB_ROLL);
            w.misc = M_CLR_PZ;
         end
         4'd7:  w = mop(1'b1, A_VZ, B_NBOUNCE, D_VY, WB_ROLL);
         4'd8:  w = mop(1'b0, A_VX, B_DT, D_VZ, WB_BOUNCE_Z);
         4'd9:  w = mop(1'b1, A_VX, B_NBOUNCE, D_NONE, WB_ADD16);
         4'd10: w = mop(1'b1, A_VY, B_NBOUNCE, D_VX, WB_BOUNCE_X);
         4'd11: begin
            w      = mop(1'b0, A_VX, B_DT, D_VY, WB_BOUNCE_Y);
            w.last = 1'b1;
         end
         4'd12: begin
            w.misc = M_KICK;
            w.last = 1'b1;
         end
         4'd13: begin
            w.misc = M_PLACE;
            w.last = 1'b1;
         end
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

   function automatic logic signed [POS_W-1:0] sat22(logic signed [SUM_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > SUM_W'(V_MAX)) begin
         r = V_MAX;
      end else if (v < SUM_W'(V_MIN)) begin
         r = V_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/bbps_sequencer.sv
// Microcode sequencer of the ball bounce physics step unit.
// Steps through the program held in bbps_pkg and hands one control word per cycle to the datapath.
// Depends on bbps_pkg.
module bbps_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_type,
   input  logic                    pz_pos,
   input  logic                    out_free,
   output bbps_pkg::uword_type     ctl,
   output logic                    busy,
   output logic                    load_out
);
   import bbps_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   uword_type         word;

   assign word = ucode(step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ctl      = '0;
      load_out = 1'b0;
      busy     = 1'b1;
      case (state_ff)
         SEQ_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = SEQ_RUN;
               step_in  = entry_of(req_code_type'(req_type));
            end
         end
         SEQ_RUN: begin
            ctl = word;
            if (word.last) begin
               state_in = SEQ_POST;
            end else if (word.jmp_air && pz_pos) begin
               step_in = word.target;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         SEQ_POST: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

endmodule

>>> rtl/bbps_datapath.sv
// Datapath of the ball bounce physics step unit: ball state, one shared multiplier, writeback.
// Driven one control word per cycle by bbps_sequencer while a program runs.
// Depends on bbps_pkg.
module bbps_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bbps_pkg::uword_type            ctl,
   input  bbps_pkg::cfg_type              cfg,
   input  bbps_pkg::item_type             item,
   output logic signed [bbps_pkg::POS_W-1:0] pos_x,
   output logic signed [bbps_pkg::POS_W-1:0] pos_y,
   output logic signed [bbps_pkg::POS_W-1:0] pos_z,
   output logic                           pz_pos
);
   import bbps_pkg::*;

   logic signed [POS_W-1:0]  px_ff, py_ff, pz_ff, vx_ff, vy_ff, vz_ff;
   logic signed [POS_W-1:0]  px_in, py_in, pz_in, vx_in, vy_in, vz_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [POS_W-1:0]  mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] rnd8_sum, rnd16_sum;
   logic signed [PROD_W-9:0] r8;
   logic signed [PROD_W-17:0] r16;
   logic signed [POS_W-1:0]  base;
   logic signed [SUM_W-1:0]  sum;
   logic signed [POS_W-1:0]  sat_val, wb_val;
   logic                     wb_en;
   logic                     in_goal;
   logic [PIX_W-1:0]         left_pix, right_pix;
   logic [PIX_W:0]           left_sum, top_sum;
   logic signed [PIX_W+1:0]  right_sum, bottom_sum;
   logic signed [POS_W-1:0]  left_q, right_q, top_q, bottom_q, goal_top_q, goal_bot_q;
   logic                     hit_left, hit_right, hit_top, hit_bottom, hit_x, hit_y;
   logic signed [POS_W-1:0]  clamp_x, clamp_y;
   logic                     clamp_x_en, clamp_y_en;

   always_comb begin
      case (ctl.mul_a)
         A_VX:    mul_a = vx_ff;
         A_VY:    mul_a = vy_ff;
         A_VZ:    mul_a = vz_ff;
         default: mul_a = GRAVITY_Q;
      endcase
      case (ctl.mul_b)
         B_DT:       mul_b = $signed({2'b00, item.dt});
         B_NBOUNCE:  mul_b = -$signed({{(MULB_W-FAC_W){1'b0}}, cfg.bounce_factor});
         B_FRICTION: mul_b = $signed({{(MULB_W-FAC_W){1'b0}}, cfg.friction});
         default:    mul_b = '0;
      endcase
   end

   assign prod_in   = mul_a * mul_b;
   assign rnd8_sum  = prod_ff + PROD_W'(128);
   assign rnd16_sum = prod_ff + PROD_W'(32768);
   assign r8        = rnd8_sum[PROD_W-1:8];
   assign r16       = rnd16_sum[PROD_W-1:16];

   always_comb begin
      case (ctl.dst)
         D_PX:    base = px_ff;
         D_PY:    base = py_ff;
         D_PZ:    base = pz_ff;
         D_VX:    base = vx_ff;
         D_VY:    base = vy_ff;
         D_VZ:    base = vz_ff;
         default: base = '0;
      endcase
      case (ctl.mode)
         WB_ADD16: sum = SUM_W'(base) + SUM_W'(r16);
         WB_SUB8:  sum = SUM_W'(base) - SUM_W'(r8);
         default:  sum = SUM_W'(r8);
      endcase
   end

   assign sat_val = sat22(sum);

   // The side walls open to the net backs while the ball lies between the goal posts.
   assign goal_top_q = $signed({2'b00, cfg.post_upper, 8'h00});
   assign goal_bot_q = $signed({2'b00, cfg.post_lower, 8'h00});
   assign in_goal    = (py_ff > goal_top_q) && (py_ff < goal_bot_q);
   assign left_pix   = in_goal ? NET_LEFT_X : cfg.left_wall;
   assign right_pix  = in_goal ? NET_RIGHT_X : cfg.right_wall;
   assign left_sum   = {1'b0, left_pix} + WALL_MARGIN;
   assign top_sum    = {1'b0, cfg.top_wall} + WALL_MARGIN;
   assign right_sum  = $signed({2'b00, right_pix}) - $signed({1'b0, WALL_MARGIN});
   assign bottom_sum = $signed({2'b00, cfg.bottom_wall}) - $signed({1'b0, WALL_MARGIN});
   assign left_q     = $signed({1'b0, left_sum, 8'h00});
   assign top_q      = $signed({1'b0, top_sum, 8'h00});
   assign right_q    = $signed({right_sum, 8'h00});
   assign bottom_q   = $signed({bottom_sum, 8'h00});

   assign hit_left   = px_ff <= left_q;
   assign hit_right  = px_ff >= right_q;
   assign hit_top    = py_ff <= top_q;
   assign hit_bottom = py_ff >= bottom_q;
   assign hit_x      = hit_left || hit_right;
   assign hit_y      = hit_top || hit_bottom;
   assign clamp_x    = hit_left ? left_q : right_q;
   assign clamp_y    = hit_top ? top_q : bottom_q;
   assign clamp_x_en = (ctl.dst != D_NONE) && (ctl.mode == WB_BOUNCE_X) && hit_x;
   assign clamp_y_en = (ctl.dst != D_NONE) && (ctl.mode == WB_BOUNCE_Y) && hit_y;

   always_comb begin
      wb_val = sat_val;
      wb_en  = (ctl.dst != D_NONE);
      case (ctl.mode)
         WB_ROLL: begin
            if (sat_val < STOP_HI && sat_val > STOP_LO) begin
               wb_val = '0;
            end
         end
         WB_BOUNCE_Z: begin
            if (!(vz_ff < BOUNCE_MIN_V)) begin
               wb_val = '0;
            end
         end
         WB_BOUNCE_X: wb_en = wb_en && hit_x;
         WB_BOUNCE_Y: wb_en = wb_en && hit_y;
         default: wb_val = sat_val;
      endcase
   end

   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      pz_in = pz_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      vz_in = vz_ff;
      if (wb_en) begin
         case (ctl.dst)
            D_PX:    px_in = wb_val;
            D_PY:    py_in = wb_val;
            D_PZ:    pz_in = wb_val;
            D_VX:    vx_in = wb_val;
            D_VY:    vy_in = wb_val;
            D_VZ:    vz_in = wb_val;
            default: px_in = px_ff;
         endcase
      end
      if (clamp_x_en) begin
         px_in = clamp_x;
      end
      if (clamp_y_en) begin
         py_in = clamp_y;
      end
      case (ctl.misc)
         M_KICK: begin
            vx_in = sat22(SUM_W'(vx_ff) + SUM_W'(item.kick_x));
            vy_in = sat22(SUM_W'(vy_ff) + SUM_W'(item.kick_y));
            vz_in = sat22(SUM_W'(vz_ff) + SUM_W'(item.kick_z));
         end
         M_PLACE: begin
            px_in = $signed({2'b00, item.place_x});
            py_in = $signed({2'b00, item.place_y});
            pz_in = '0;
            vx_in = '0;
            vy_in = '0;
            vz_in = '0;
         end
         M_CLR_PZ: pz_in = '0;
         default: pz_in = pz_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         pz_ff <= '0;
         vx_ff <= '0;
         vy_ff <= '0;
         vz_ff <= '0;
      end else begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         vz_ff <= vz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign pos_x  = px_ff;
   assign pos_y  = py_ff;
   assign pos_z  = pz_ff;
   assign pz_pos = pz_ff > POS_W'(0);

endmodule

>>> rtl/ball_bounce_physics_step_unit.sv
// Top level of the ball bounce physics step unit: handshakes, configuration registers, result register.
// Instantiates bbps_sequencer and bbps_datapath; depends on bbps_pkg.
//
// The unit keeps one ball's position and velocity and takes one item at a time. A tick
// runs a short microcode program on one shared multiplier: 12 steps when the ball ends
// on the ground and 9 when it stays in the air; kick, place and the unused request use no
// multiplier. A new item is taken only once the last one's result is loaded. The
// result waits in an output register, so the next item is taken while it is stalled.
// Configuration writes are always ready and belong in idle periods only.
module ball_bounce_physics_step_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [bbps_pkg::DT_W-1:0]         req_dt,
   input  logic signed [bbps_pkg::POS_W-1:0] req_kick_x,
   input  logic signed [bbps_pkg::POS_W-1:0] req_kick_y,
   input  logic signed [bbps_pkg::POS_W-1:0] req_kick_z,
   input  logic [bbps_pkg::POS_W-3:0]        req_place_x,
   input  logic [bbps_pkg::POS_W-3:0]        req_place_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bbps_pkg::POS_W-1:0] rsp_ball_x,
   output logic signed [bbps_pkg::POS_W-1:0] rsp_ball_y,
   output logic signed [bbps_pkg::POS_W-1:0] rsp_ball_z,
   output logic                              rsp_grounded,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [bbps_pkg::PIX_W-1:0]        csr_data
);
   import bbps_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   item_type                item_ff;
   uword_type               ctl;
   logic                    busy, load_out, pz_pos, accept, out_free;
   logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] ball_x_ff, ball_y_ff, ball_z_ff;
   logic                    grounded_ff;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BOUNCE_FACTOR: cfg_in.bounce_factor = csr_data[FAC_W-1:0];
            CSR_FRICTION:      cfg_in.friction      = csr_data[FAC_W-1:0];
            CSR_LEFT_WALL:     cfg_in.left_wall     = csr_data;
            CSR_RIGHT_WALL:    cfg_in.right_wall    = csr_data;
            CSR_TOP_WALL:      cfg_in.top_wall      = csr_data;
            CSR_BOTTOM_WALL:   cfg_in.bottom_wall   = csr_data;
            CSR_POST_UPPER:    cfg_in.post_upper    = csr_data;
            CSR_POST_LOWER:    cfg_in.post_lower    = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bounce_factor <= FAC_W'(154);
         cfg_ff.friction      <= FAC_W'(251);
         cfg_ff.left_wall     <= '0;
         cfg_ff.right_wall    <= PIX_W'(1280);
         cfg_ff.top_wall      <= '0;
         cfg_ff.bottom_wall   <= PIX_W'(720);
         cfg_ff.post_upper    <= '0;
         cfg_ff.post_lower    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.dt      <= req_dt;
         item_ff.kick_x  <= req_kick_x;
         item_ff.kick_y  <= req_kick_y;
         item_ff.kick_z  <= req_kick_z;
         item_ff.place_x <= req_place_x;
         item_ff.place_y <= req_place_y;
      end
   end

   bbps_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .req_type (req_type),
      .pz_pos   (pz_pos),
      .out_free (out_free),
      .ctl      (ctl),
      .busy     (busy),
      .load_out (load_out)
   );

   bbps_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .cfg    (cfg_ff),
      .item   (item_ff),
      .pos_x  (pos_x),
      .pos_y  (pos_y),
      .pos_z  (pos_z),
      .pz_pos (pz_pos)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         ball_x_ff   <= pos_x;
         ball_y_ff   <= pos_y;
         ball_z_ff   <= pos_z;
         grounded_ff <= !pz_pos;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ball_x   = ball_x_ff;
   assign rsp_ball_y   = ball_y_ff;
   assign rsp_ball_z   = ball_z_ff;
   assign rsp_grounded = grounded_ff;

endmodule

>>> tb/ball_bounce_physics_step_unit_tb.sv
// Testbench for ball_bounce_physics_step_unit: a directed table of ball events, then random
// play under several register settings, every result checked against a fixed expected view or an in-bench ball model.
// Depends on bbps_pkg and the unit's RTL only.
module ball_bounce_physics_step_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bbps_pkg::*;

   localparam longint Q_ONE        = 256;
   localparam longint G_ACCEL      = 800;
   localparam longint PITCH_SPAN   = 1280;
   localparam longint NET_BACK     = 10;
   localparam longint WALL_GAP     = 16;
   localparam longint BOUNCE_SPEED = 50 * Q_ONE;
   localparam longint STOP_SPEED   = 5 * Q_ONE;

   localparam logic signed [POS_W-1:0] ZERO_Q = '0;
   localparam logic signed [POS_W-1:0] Q_MAX  = 22'sh1FFFFF;
   localparam logic signed [POS_W-1:0] Q_MIN  = 22'sh200000;
   localparam logic signed [POS_W-1:0] MID_XQ = 22'sd163840;
   localparam logic signed [POS_W-1:0] MID_YQ = 22'sd92160;
   localparam logic signed [POS_W-1:0] FAR_Q  = 22'sd1048575;
   localparam logic [POS_W-3:0]        NO_PL  = '0;
   localparam logic [POS_W-3:0]        FAR_P  = '1;
   localparam logic [POS_W-3:0]        MID_XP = 20'd163840;
   localparam logic [POS_W-3:0]        MID_YP = 20'd92160;

   typedef struct packed {
      req_code_type            kind;
      logic [DT_W-1:0]         dt;
      logic signed [POS_W-1:0] kick_x;
      logic signed [POS_W-1:0] kick_y;
      logic signed [POS_W-1:0] kick_z;
      logic [POS_W-3:0]        place_x;
      logic [POS_W-3:0]        place_y;
   } ball_event_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic                    grounded;
   } ball_view_type;

   typedef struct packed {
      ball_event_type ev;
      logic           typed;
      ball_view_type  want;
   } directed_row_type;

   localparam ball_view_type UNTYPED   = '0;
   localparam ball_view_type AT_ORIGIN = '{ZERO_Q, ZERO_Q, ZERO_Q, 1'b1};
   localparam ball_view_type AT_FAR    = '{FAR_Q, FAR_Q, ZERO_Q, 1'b1};
   localparam ball_view_type AT_MID    = '{MID_XQ, MID_YQ, ZERO_Q, 1'b1};

   localparam directed_row_type DIRECTED [24] = '{
      '{'{REQ_NONE, 16'd0, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b1, AT_ORIGIN},
      '{'{REQ_KICK, 16'd0, Q_MAX, Q_MAX, Q_MAX, NO_PL, NO_PL}, 1'b1, AT_ORIGIN},
      '{'{REQ_KICK, 16'd0, Q_MIN, Q_MIN, Q_MIN, NO_PL, NO_PL}, 1'b1, AT_ORIGIN},
      '{'{REQ_TICK, 16'd0, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_PLACE, 16'd0, ZERO_Q, ZERO_Q, ZERO_Q, FAR_P, FAR_P}, 1'b1, AT_FAR},
      '{'{REQ_NONE, 16'd0, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b1, AT_FAR},
      '{'{REQ_TICK, 16'hFFFF, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_PLACE, 16'd0, ZERO_Q, ZERO_Q, ZERO_Q, MID_XP, MID_YP}, 1'b1, AT_MID},
      '{'{REQ_KICK, 16'd0, 22'sd25600, -22'sd25600, 22'sd128000, NO_PL, NO_PL},
        1'b1, AT_MID},
      '{'{REQ_TICK, 16'hFFFF, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_TICK, 16'd8192, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_TICK, 16'd8192, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_TICK, 16'd16384, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_KICK, 16'd0, ZERO_Q, ZERO_Q, -22'sd25600, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_TICK, 16'd4096, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_TICK, 16'd4096, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_KICK, 16'd0, Q_MAX, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_TICK, 16'hFFFF, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_KICK, 16'd0, Q_MIN, Q_MIN, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_TICK, 16'hFFFF, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_PLACE, 16'd0, ZERO_Q, ZERO_Q, ZERO_Q, MID_XP, MID_YP}, 1'b1, AT_MID},
      '{'{REQ_KICK, 16'd0, 22'sd768, -22'sd768, ZERO_Q, NO_PL, NO_PL}, 1'b1, AT_MID},
      '{'{REQ_TICK, 16'd1092, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED},
      '{'{REQ_NONE, 16'd0, ZERO_Q, ZERO_Q, ZERO_Q, NO_PL, NO_PL}, 1'b0, UNTYPED}
   };

   localparam csr_index_type REG_ORDER [8] = '{
      CSR_BOUNCE_FACTOR, CSR_FRICTION, CSR_LEFT_WALL, CSR_RIGHT_WALL,
      CSR_TOP_WALL, CSR_BOTTOM_WALL, CSR_POST_UPPER, CSR_POST_LOWER
   };

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_type    = REQ_TICK;
   logic [DT_W-1:0]         req_dt      = '0;
   logic signed [POS_W-1:0] req_kick_x  = '0;
   logic signed [POS_W-1:0] req_kick_y  = '0;
   logic signed [POS_W-1:0] req_kick_z  = '0;
   logic [POS_W-3:0]        req_place_x = '0;
   logic [POS_W-3:0]        req_place_y = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   logic signed [POS_W-1:0] rsp_ball_x;
   logic signed [POS_W-1:0] rsp_ball_y;
   logic signed [POS_W-1:0] rsp_ball_z;
   logic                    rsp_grounded;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   logic [2:0]              csr_index   = CSR_BOUNCE_FACTOR;
   logic [PIX_W-1:0]        csr_data    = '0;

   logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
   logic signed [POS_W-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
   cfg_type                 cfg;
   ball_view_type           ball_positions_due [$];
   int                      mismatches  = 0;
   int                      hold_cycles = 0;
   bit                      calm        = 1'b0;

   ball_bounce_physics_step_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_dt       (req_dt),
      .req_kick_x   (req_kick_x),
      .req_kick_y   (req_kick_y),
      .req_kick_z   (req_kick_z),
      .req_place_x  (req_place_x),
      .req_place_y  (req_place_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ball_x   (rsp_ball_x),
      .rsp_ball_y   (rsp_ball_y),
      .rsp_ball_z   (rsp_ball_z),
      .rsp_grounded (rsp_grounded),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #1 clock = ~clock;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_q(longint v);
      if (v > longint'(Q_MAX)) begin
         return Q_MAX;
      end
      if (v < longint'(Q_MIN)) begin
         return Q_MIN;
      end
      return POS_W'(v);
   endfunction

   function automatic logic signed [POS_W-1:0] rebound(logic signed [POS_W-1:0] v);
      return clamp_q(round_shift(-longint'(v) * longint'(cfg.bounce_factor), 8));
   endfunction

   function automatic logic signed [POS_W-1:0] roll(logic signed [POS_W-1:0] v);
      logic signed [POS_W-1:0] r;
      r = clamp_q(round_shift(longint'(v) * longint'(cfg.friction), 8));
      if (longint'(r) < STOP_SPEED && longint'(r) > -STOP_SPEED) begin
         r = '0;
      end
      return r;
   endfunction

   function automatic ball_view_type step_ball(ball_event_type ev);
      longint        dt, lo, hi, top, bottom;
      ball_view_type v;
      case (ev.kind)
         REQ_TICK: begin
            dt    = longint'(ev.dt);
            vel_z = clamp_q(longint'(vel_z) - round_shift(G_ACCEL * dt, 8));
            pos_x = clamp_q(longint'(pos_x) + round_shift(longint'(vel_x) * dt, 16));
            pos_y = clamp_q(longint'(pos_y) + round_shift(longint'(vel_y) * dt, 16));
            pos_z = clamp_q(longint'(pos_z) + round_shift(longint'(vel_z) * dt, 16));
            if (pos_z <= 0) begin
               pos_z = '0;
               if (longint'(vel_z) < -BOUNCE_SPEED) begin
                  vel_z = rebound(vel_z);
               end else begin
                  vel_z = '0;
               end
               vel_x = roll(vel_x);
               vel_y = roll(vel_y);
            end
            lo = longint'(cfg.left_wall);
            hi = longint'(cfg.right_wall);
            if (longint'(pos_y) > longint'(cfg.post_upper) * Q_ONE &&
                longint'(pos_y) < longint'(cfg.post_lower) * Q_ONE) begin
               lo = NET_BACK;
               hi = PITCH_SPAN - NET_BACK;
            end
            lo = (lo + WALL_GAP) * Q_ONE;
            hi = (hi - WALL_GAP) * Q_ONE;
            if (longint'(pos_x) <= lo) begin
               pos_x = clamp_q(lo);
               vel_x = rebound(vel_x);
            end else if (longint'(pos_x) >= hi) begin
               pos_x = clamp_q(hi);
               vel_x = rebound(vel_x);
            end
            top    = (longint'(cfg.top_wall) + WALL_GAP) * Q_ONE;
            bottom = (longint'(cfg.bottom_wall) - WALL_GAP) * Q_ONE;
            if (longint'(pos_y) <= top) begin
               pos_y = clamp_q(top);
               vel_y = rebound(vel_y);
            end else if (longint'(pos_y) >= bottom) begin
               pos_y = clamp_q(bottom);
               vel_y = rebound(vel_y);
            end
         end
         REQ_KICK: begin
            vel_x = clamp_q(longint'(vel_x) + longint'(ev.kick_x));
            vel_y = clamp_q(longint'(vel_y) + longint'(ev.kick_y));
            vel_z = clamp_q(longint'(vel_z) + longint'(ev.kick_z));
         end
         REQ_PLACE: begin
            pos_x = {2'b00, ev.place_x};
            pos_y = {2'b00, ev.place_y};
            pos_z = '0;
            vel_x = '0;
            vel_y = '0;
            vel_z = '0;
         end
         default: begin
         end
      endcase
      v.x        = pos_x;
      v.y        = pos_y;
      v.z        = pos_z;
      v.grounded = (pos_z <= 0);
      return v;
   endfunction

   task automatic offer(input ball_event_type ev, input logic typed,
                        input ball_view_type want);
      int            gap;
      ball_view_type got;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= ev.kind;
      req_dt      <= ev.dt;
      req_kick_x  <= ev.kick_x;
      req_kick_y  <= ev.kick_y;
      req_kick_z  <= ev.kick_z;
      req_place_x <= ev.place_x;
      req_place_y <= ev.place_y;
      do @(posedge clock); while (req_stall !== 1'b0);
      got = step_ball(ev);
      ball_positions_due.push_back(typed ? want : got);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (ball_positions_due.size() != 0);
   endtask

   task automatic flag(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endtask

   initial begin : result_side
      int            n;
      ball_view_type want;
      forever begin
         if (hold_cycles != 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         n = calm ? 0 : $urandom_range(0, 5);
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (ball_positions_due.size() == 0) begin
            flag($sformatf("unexpected result x=%0d y=%0d z=%0d g=%0b",
                           rsp_ball_x, rsp_ball_y, rsp_ball_z, rsp_grounded));
         end else begin
            want = ball_positions_due.pop_front();
            if (rsp_ball_x !== want.x || rsp_ball_y !== want.y ||
                rsp_ball_z !== want.z || rsp_grounded !== want.grounded) begin
               flag($sformatf({"mismatch: expected x=%0d y=%0d z=%0d g=%0b, ",
                               "got x=%0d y=%0d z=%0d g=%0b"},
                              want.x, want.y, want.z, want.grounded,
                              rsp_ball_x, rsp_ball_y, rsp_ball_z, rsp_grounded));
            end
         end
      end
   end

   initial begin : stimulus
      ball_event_type   ev;
      logic [PIX_W-1:0] vals [8];
      int               r;
      cfg = '{9'd154, 9'd251, 12'd0, 12'd1280, 12'd0, 12'd720, 12'd0, 12'd0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i]) begin
         offer(DIRECTED[i].ev, DIRECTED[i].typed, DIRECTED[i].want);
      end
      for (int phase = 0; phase < 7; phase++) begin
         drain();
         case (phase)
            0: vals = '{12'd154, 12'd251, 12'd0, 12'd1280, 12'd0, 12'd720, 12'd300, 12'd420};
            1: vals = '{12'd256, 12'd256, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095};
            2: vals = '{12'd0, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0};
            3: vals = '{12'd4095, 12'd4095, 12'd4095, 12'd4095,
                        12'd4095, 12'd4095, 12'd4095, 12'd4095};
            6: foreach (vals[i]) vals[i] = PIX_W'($urandom());
            default: vals = '{PIX_W'($urandom_range(0, 256)), PIX_W'($urandom_range(200, 256)),
                              PIX_W'($urandom_range(0, 64)), PIX_W'($urandom_range(1100, 1300)),
                              PIX_W'($urandom_range(0, 64)), PIX_W'($urandom_range(600, 760)),
                              PIX_W'($urandom_range(200, 340)),
                              PIX_W'($urandom_range(380, 520))};
         endcase
         for (int i = 0; i < 8; i++) begin
            csr_valid <= 1'b1;
            csr_index <= REG_ORDER[i];
            csr_data  <= vals[i];
            do @(posedge clock); while (csr_ready !== 1'b1);
            case (REG_ORDER[i])
               CSR_BOUNCE_FACTOR: cfg.bounce_factor = vals[i][FAC_W-1:0];
               CSR_FRICTION:      cfg.friction      = vals[i][FAC_W-1:0];
               CSR_LEFT_WALL:     cfg.left_wall     = vals[i];
               CSR_RIGHT_WALL:    cfg.right_wall    = vals[i];
               CSR_TOP_WALL:      cfg.top_wall      = vals[i];
               CSR_BOTTOM_WALL:   cfg.bottom_wall   = vals[i];
               CSR_POST_UPPER:    cfg.post_upper    = vals[i];
               default:           cfg.post_lower    = vals[i];
            endcase
         end
         csr_valid <= 1'b0;
         calm = (phase == 2);
         if (phase == 1) begin
            hold_cycles = 200;
         end
         for (int n = 0; n < 200; n++) begin
            if (phase == 3 && n == 100) begin
               drain();
            end
            r  = $urandom_range(0, 99);
            ev = '0;
            if (r < 62) begin
               ev.kind = REQ_TICK;
               ev.dt   = ($urandom_range(0, 4) == 0) ? DT_W'($urandom())
                                                     : DT_W'($urandom_range(0, 2200));
            end else if (r < 80) begin
               ev.kind = REQ_KICK;
               if ($urandom_range(0, 6) == 0) begin
                  ev.kick_x = POS_W'($urandom());
                  ev.kick_y = POS_W'($urandom());
                  ev.kick_z = POS_W'($urandom());
               end else begin
                  ev.kick_x = POS_W'(int'($urandom_range(0, 307200)) - 153600);
                  ev.kick_y = POS_W'(int'($urandom_range(0, 307200)) - 153600);
                  ev.kick_z = POS_W'(int'($urandom_range(0, 179200)) - 25600);
               end
            end else if (r < 92) begin
               ev.kind = REQ_PLACE;
               if ($urandom_range(0, 4) == 0) begin
                  ev.place_x = (POS_W-2)'($urandom());
                  ev.place_y = (POS_W-2)'($urandom());
               end else begin
                  ev.place_x = (POS_W-2)'($urandom_range(0, 358400));
                  ev.place_y = (POS_W-2)'($urandom_range(0, 204800));
               end
            end else if (r < 96) begin
               ev.kind = REQ_NONE;
               ev.dt   = DT_W'($urandom());
            end else begin
               ev.kind = REQ_TICK;
               ev.dt   = DT_W'($urandom());
            end
            offer(ev, 1'b0, UNTYPED);
         end
      end
      calm = 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && ball_positions_due.size() == 0) begin
         $display("ball_bounce_physics_step_unit_tb passed");
      end else begin
         $display("ball_bounce_physics_step_unit_tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("ball_bounce_physics_step_unit_tb failed");
      $finish;
   end

endmodule

>>> ball_bounce_physics_step_unit.f
rtl/bbps_pkg.sv
rtl/bbps_sequencer.sv
rtl/bbps_datapath.sv
rtl/ball_bounce_physics_step_unit.sv
tb/ball_bounce_physics_step_unit_tb.sv
